// ===== hw/rtl/lcp_pkg.sv =====
package lcp_pkg;

    localparam int PIXEL_BITS_DEF      = 16;
    localparam int TABLE_ADDR_BITS_DEF = 10;

    // Configuration register map.
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_L       = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_ALPHA   = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_BETA    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_OFFSET_L     = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_OFFSET_ALPHA = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_OFFSET_BETA  = 3'd5;

    localparam int GAIN_BITS   = 16;
    localparam int OFFSET_BITS = 24;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd4096;

    // Internal datapath widths (Q.16 signed unless noted).
    localparam int LG_W   = 22;  // log10 of an LMS value
    localparam int LABM_W = 24;  // l-alpha-beta before gain
    localparam int LAB_W  = 27;  // l-alpha-beta after gain and offset
    localparam int V_W    = 28;  // log10 LMS after the inverse matrix
    localparam int LIN_W  = 31;  // linear LMS, unsigned
    localparam int LOG2_W = 16;  // log2 table entry
    localparam int EXP2_W = 31;  // exp2 table entry, Q.30

    localparam logic signed [LG_W-1:0] LOG_FLOOR = -22'sd589824;
    localparam int LOG10_2_Q16 = 19728;
    localparam int LOG2_10_Q16 = 217706;

    typedef logic [15:0]        ucoef_t;
    typedef logic signed [20:0] scoef_t;

    // Columns R, G, B.
    localparam ucoef_t RGB_TO_LMS [3][3] = '{
        '{16'd24976, 16'd37899, 16'd2635},
        '{16'd12891, 16'd47474, 16'd5125},
        '{16'd1579,  16'd8441,  16'd55339}};
    localparam scoef_t LMS_TO_LAB [3][3] = '{
        '{21'sd37840, 21'sd37840, 21'sd37840},
        '{21'sd26752, 21'sd26752, -21'sd53510},
        '{21'sd46341, -21'sd46341, 21'sd0}};
    localparam scoef_t LAB_TO_LMS [3][3] = '{
        '{21'sd37840, 21'sd26752, 21'sd46341},
        '{21'sd37840, 21'sd26752, -21'sd46341},
        '{21'sd37840, -21'sd53510, 21'sd0}};
    // Rows R, G, B.
    localparam scoef_t LMS_TO_RGB [3][3] = '{
        '{21'sd292808, -21'sd235097, 21'sd7818},
        '{-21'sd79862, 21'sd156035, -21'sd10643},
        '{21'sd3257, -21'sd15984, 21'sd78938}};

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bit_v;
        x = x_in;
        res = 64'd0;
        bit_v = 64'd1 << 62;
        while (bit_v > x)
            bit_v = bit_v >> 2;
        while (bit_v != 64'd0)
        begin
            if (x >= res + bit_v)
            begin
                x = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // Fraction of log2(1 + idx/2^abits) in Q.16, found bit by bit by squaring.
    function automatic logic [LOG2_W-1:0] log2_entry(input int unsigned idx,
                                                     input int unsigned abits);
        logic [63:0] y;
        logic [LOG2_W-1:0] res;
        y = (64'd1 << 30) + (64'(idx) << (30 - abits));
        res = '0;
        for (int k = 0; k < LOG2_W; k++)
        begin
            y = (y * y) >> 30;
            res = {res[LOG2_W-2:0], 1'b0};
            if (y >= (64'd1 << 31))
            begin
                res[0] = 1'b1;
                y = y >> 1;
            end
        end
        return res;
    endfunction

    // 2^(idx/2^abits) in Q.30 as a product of repeated square roots of two.
    function automatic logic [EXP2_W-1:0] exp2_entry(input int unsigned idx,
                                                     input int unsigned abits);
        logic [63:0] r;
        logic [63:0] root;
        r = 64'd1 << 30;
        root = 64'd1 << 31;
        for (int k = 1; k <= int'(abits); k++)
        begin
            root = isqrt64(root << 30);
            if (((idx >> (int'(abits) - k)) & 1) != 0)
                r = (r * root) >> 30;
        end
        return EXP2_W'(r);
    endfunction

endpackage

// ===== hw/rtl/lab_color_transfer_pixel_core.sv =====
// Color transfer in l-alpha-beta space, one pixel per transaction.
// Input channel: in_valid/in_ready with blue_in, green_in, red_in (unsigned
// Q0.PIXEL_BITS). Output channel: out_valid/out_ready with blue_out,
// green_out, red_out and clipped, which is high when any channel saturated.
// Configuration: cfg_wr_en writes cfg_wr_data into the register selected by
// cfg_addr (gains Q4.12, offsets signed Q8.16); unknown indexes are ignored.
// Write configuration only while no transaction is in flight.
// The pipeline has 16 register stages, and one pixel is accepted every cycle
// while the output is taken. The log2 and exp2 tables are synchronous ROMs,
// one per channel. When the receiver holds out_ready low with a result
// waiting, the whole pipeline freezes and in_ready drops in the same cycle;
// nothing is lost or repeated. Reset clears the valid bits and loads unity
// gains and zero offsets.
module lab_color_transfer_pixel_core #(
    parameter int PIXEL_BITS      = lcp_pkg::PIXEL_BITS_DEF,
    parameter int TABLE_ADDR_BITS = lcp_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [lcp_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [lcp_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [PIXEL_BITS-1:0]                blue_in,
    input  logic [PIXEL_BITS-1:0]                green_in,
    input  logic [PIXEL_BITS-1:0]                red_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [PIXEL_BITS-1:0]                blue_out,
    output logic [PIXEL_BITS-1:0]                green_out,
    output logic [PIXEL_BITS-1:0]                red_out,
    output logic                                 clipped
);
    import lcp_pkg::*;

    localparam int P      = PIXEL_BITS;
    localparam int A      = TABLE_ADDR_BITS;
    localparam int NSTAGE = 16;
    localparam int P1_W   = P + 16;
    localparam int S1_W   = P + 18;
    localparam int P2_W   = 40;
    localparam int S2_W   = 42;
    localparam int GP_W   = 41;
    localparam int P3_W   = 45;
    localparam int S3_W   = 47;
    localparam int P4_W   = 52;
    localparam int S4_W   = 54;
    localparam int W_W    = 38;
    localparam logic signed [W_W-1:0] PIX_MAX = W_W'((64'd1 << P) - 64'd1);

    logic en;
    logic [NSTAGE-1:0] vld_reg;

    logic [GAIN_BITS-1:0]   gain_reg [3];
    logic [OFFSET_BITS-1:0] off_reg [3];

    logic [P-1:0] rgb [3];

    logic [P1_W-1:0]          p1_reg [3][3];
    logic [S1_W-1:0]          s1 [3];
    logic [P-1:0]             lms_reg [3];
    logic signed [LG_W-1:0]   lg [3];
    logic signed [P2_W-1:0]   p2_reg [3][3];
    logic signed [S2_W-1:0]   s2 [3];
    logic signed [LABM_W-1:0] labm_reg [3];
    logic signed [GP_W-1:0]   gp_reg [3];
    logic signed [LAB_W-1:0]  lab_reg [3];
    logic signed [P3_W-1:0]   p3_reg [3][3];
    logic signed [S3_W-1:0]   s3 [3];
    logic signed [V_W-1:0]    v_reg [3];
    logic [LIN_W-1:0]         lin [3];
    logic signed [P4_W-1:0]   p4_reg [3][3];
    logic signed [S4_W-1:0]   s4 [3];
    logic signed [W_W-1:0]    w [3];
    logic [P-1:0]             pix_next [3];
    logic [P-1:0]             pix_reg [3];
    logic                     clip_next;
    logic                     clip_reg;

    // The pipeline moves as one; it holds only while a finished result waits.
    assign en = !vld_reg[NSTAGE-1] || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                gain_reg[i] <= GAIN_RESET;
                off_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_GAIN_L:       gain_reg[0] <= cfg_wr_data[GAIN_BITS-1:0];
                REG_GAIN_ALPHA:   gain_reg[1] <= cfg_wr_data[GAIN_BITS-1:0];
                REG_GAIN_BETA:    gain_reg[2] <= cfg_wr_data[GAIN_BITS-1:0];
                REG_OFFSET_L:     off_reg[0] <= cfg_wr_data[OFFSET_BITS-1:0];
                REG_OFFSET_ALPHA: off_reg[1] <= cfg_wr_data[OFFSET_BITS-1:0];
                REG_OFFSET_BETA:  off_reg[2] <= cfg_wr_data[OFFSET_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign rgb[0] = red_in;
    assign rgb[1] = green_in;
    assign rgb[2] = blue_in;

    // RGB to LMS.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    p1_reg[r][c] <= P1_W'(RGB_TO_LMS[r][c]) * P1_W'(rgb[c]);
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            s1[r] = S1_W'(p1_reg[r][0]) + S1_W'(p1_reg[r][1])
                  + S1_W'(p1_reg[r][2]) + S1_W'(32768);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                lms_reg[r] <= s1[r][P+15:16];
        end
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_log
        lcp_log10 #(.PIXEL_BITS(P), .TABLE_ADDR_BITS(A)) u_log10 (
            .clk (clk),
            .en  (en),
            .lms (lms_reg[r]),
            .lg  (lg[r])
        );
    end

    // Decorrelating matrix, then gain and offset per channel.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    p2_reg[r][c] <= P2_W'(LMS_TO_LAB[r][c]) * P2_W'(lg[c]);
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            s2[r] = S2_W'(p2_reg[r][0]) + S2_W'(p2_reg[r][1])
                  + S2_W'(p2_reg[r][2]) + S2_W'(32768);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                labm_reg[r] <= LABM_W'(s2[r] >>> 16);
                gp_reg[r] <= GP_W'(labm_reg[r]) * GP_W'($signed({1'b0, gain_reg[r]}));
                lab_reg[r] <= LAB_W'((gp_reg[r] + GP_W'(2048)) >>> 12)
                            + LAB_W'($signed(off_reg[r]));
            end
        end
    end

    // Inverse decorrelating matrix.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    p3_reg[r][c] <= P3_W'(LAB_TO_LMS[r][c]) * P3_W'(lab_reg[c]);
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            s3[r] = S3_W'(p3_reg[r][0]) + S3_W'(p3_reg[r][1])
                  + S3_W'(p3_reg[r][2]) + S3_W'(32768);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                v_reg[r] <= V_W'(s3[r] >>> 16);
        end
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_pow
        lcp_pow10 #(.PIXEL_BITS(P), .TABLE_ADDR_BITS(A)) u_pow10 (
            .clk (clk),
            .en  (en),
            .v   (v_reg[r]),
            .lin (lin[r])
        );
    end

    // LMS to RGB, rounded and saturated.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    p4_reg[r][c] <= P4_W'(LMS_TO_RGB[r][c])
                                  * P4_W'($signed({1'b0, lin[c]}));
        end
    end

    always_comb
    begin
        clip_next = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            s4[r] = S4_W'(p4_reg[r][0]) + S4_W'(p4_reg[r][1])
                  + S4_W'(p4_reg[r][2]) + S4_W'(32768);
            w[r] = W_W'(s4[r] >>> 16);
            if (w[r] < 0)
            begin
                pix_next[r] = '0;
                clip_next = 1'b1;
            end
            else if (w[r] > PIX_MAX)
            begin
                pix_next[r] = PIX_MAX[P-1:0];
                clip_next = 1'b1;
            end
            else
            begin
                pix_next[r] = w[r][P-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                pix_reg[r] <= pix_next[r];
            clip_reg <= clip_next;
        end
    end

    assign red_out   = pix_reg[0];
    assign green_out = pix_reg[1];
    assign blue_out  = pix_reg[2];
    assign clipped   = clip_reg;

endmodule

// ===== hw/rtl/lcp_log2_rom.sv =====
module lcp_log2_rom #(
    parameter int ADDR_BITS = lcp_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [ADDR_BITS-1:0]         addr,
    output logic [lcp_pkg::LOG2_W-1:0]   data
);
    import lcp_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [LOG2_W-1:0] rom [DEPTH];
    logic [LOG2_W-1:0] data_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_rom
        assign rom[i] = log2_entry(i, ADDR_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= rom[addr];
    end

    assign data = data_reg;

endmodule

// ===== hw/rtl/lcp_exp2_rom.sv =====
module lcp_exp2_rom #(
    parameter int ADDR_BITS = lcp_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [ADDR_BITS-1:0]         addr,
    output logic [lcp_pkg::EXP2_W-1:0]   data
);
    import lcp_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [EXP2_W-1:0] rom [DEPTH];
    logic [EXP2_W-1:0] data_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_rom
        assign rom[i] = exp2_entry(i, ADDR_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= rom[addr];
    end

    assign data = data_reg;

endmodule

// ===== hw/rtl/lcp_log10.sv =====
module lcp_log10 #(
    parameter int PIXEL_BITS      = lcp_pkg::PIXEL_BITS_DEF,
    parameter int TABLE_ADDR_BITS = lcp_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic [PIXEL_BITS-1:0]             lms,
    output logic signed [lcp_pkg::LG_W-1:0]   lg
);
    import lcp_pkg::*;

    localparam int P  = PIXEL_BITS;
    localparam int A  = TABLE_ADDR_BITS;
    localparam int EW = $clog2(P);
    localparam int L2_W = 23;
    localparam int PR_W = 38;

    logic [EW-1:0]  e;
    logic [P-1:0]   frac;
    logic [P+A-1:0] norm;
    logic [A-1:0]   idx;

    logic [EW-1:0]       e_reg;
    logic                zero_reg;
    logic [LOG2_W-1:0]   rom_data;
    logic signed [L2_W-1:0] l2;
    logic signed [PR_W-1:0] prod_next;
    logic signed [PR_W-1:0] prod_reg;
    logic                zero2_reg;
    logic signed [LG_W-1:0] lg_next;
    logic signed [LG_W-1:0] lg_reg;

    // Leading one gives the exponent; the bits below it, aligned to the
    // table width, give the mantissa index.
    always_comb
    begin
        e = '0;
        for (int b = 0; b < P; b++)
        begin
            if (lms[b])
                e = EW'(b);
        end
        frac = lms;
        frac[e] = 1'b0;
        norm = {frac, {A{1'b0}}} >> e;
        idx = norm[A-1:0];
    end

    lcp_log2_rom #(.ADDR_BITS(A)) u_rom (
        .clk  (clk),
        .en   (en),
        .addr (idx),
        .data (rom_data)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg <= e;
            zero_reg <= (lms == '0);
        end
    end

    always_comb
    begin
        l2 = L2_W'({e_reg, rom_data}) - L2_W'(P * 65536);
        prod_next = PR_W'(l2) * PR_W'(LOG10_2_Q16);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            zero2_reg <= zero_reg;
        end
    end

    always_comb
    begin
        if (zero2_reg)
            lg_next = LOG_FLOOR;
        else
            lg_next = LG_W'((prod_reg + PR_W'(32768)) >>> 16);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lg_reg <= lg_next;
    end

    assign lg = lg_reg;

endmodule

// ===== hw/rtl/lcp_pow10.sv =====
module lcp_pow10 #(
    parameter int PIXEL_BITS      = lcp_pkg::PIXEL_BITS_DEF,
    parameter int TABLE_ADDR_BITS = lcp_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [lcp_pkg::V_W-1:0]    v,
    output logic [lcp_pkg::LIN_W-1:0]         lin
);
    import lcp_pkg::*;

    localparam int P    = PIXEL_BITS;
    localparam int A    = TABLE_ADDR_BITS;
    localparam int PR_W = 47;
    localparam int U_W  = 31;
    localparam int SH_W = 17;
    localparam logic [LIN_W-1:0] LIN_MAX = LIN_W'((64'd1 << (P + 4)) - 64'd1);

    logic signed [PR_W-1:0] prod_reg;
    logic signed [U_W-1:0]  u;
    logic signed [SH_W-1:0] sh;
    logic [A-1:0]           idx;

    logic [EXP2_W-1:0] ent;
    logic              sat_reg;
    logic              zero_reg;
    logic [4:0]        amt_reg;
    logic [LIN_W-1:0]  lin_next;
    logic [LIN_W-1:0]  lin_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= PR_W'(v) * PR_W'(LOG2_10_Q16);
    end

    // u is log2 in Q.16; its integer part sets the final shift and the top
    // fraction bits address the table.
    always_comb
    begin
        u = U_W'((prod_reg + PR_W'(32768)) >>> 16);
        sh = SH_W'(u >>> 16) + SH_W'(P) - SH_W'(30);
        idx = u[15:16-A];
    end

    lcp_exp2_rom #(.ADDR_BITS(A)) u_rom (
        .clk  (clk),
        .en   (en),
        .addr (idx),
        .data (ent)
    );

    // Any left shift of a Q.30 entry already lies above the linear limit.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg <= (sh >= SH_W'(0));
            zero_reg <= (sh < -SH_W'(31));
            amt_reg <= 5'(-sh);
        end
    end

    always_comb
    begin
        if (sat_reg)
            lin_next = LIN_MAX;
        else if (zero_reg)
            lin_next = '0;
        else
            lin_next = LIN_W'(ent >> amt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lin_reg <= lin_next;
    end

    assign lin = lin_reg;

endmodule

// ===== tb/lab_transfer_checker.sv =====
module lab_transfer_checker
    import lcp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wr_data,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [15:0]              blue_in,
    input  logic [15:0]              green_in,
    input  logic [15:0]              red_in,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [15:0]              blue_out,
    input  logic [15:0]              green_out,
    input  logic [15:0]              red_out,
    input  logic                     clipped,
    output int                       failures,
    output int                       pending
);

    localparam int TBL_SIZE = 1 << TABLE_ADDR_BITS_DEF;
    localparam longint LIN_LIMIT = (longint'(1) << 20) - 1;

    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
        logic        clip;
    } pixel_result_t;

    pixel_result_t expected_pixels[$];
    logic [GAIN_BITS-1:0]          gain_reg[3];
    logic signed [OFFSET_BITS-1:0] offset_reg[3];
    longint log2_frac_tbl[TBL_SIZE];
    longint exp2_tbl[TBL_SIZE];

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned trial;
        res = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = res | (longint'(1) << b);
            if (trial * trial <= x)
                res = trial;
        end
        return res;
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint log10_q16(input longint x);
        int     e;
        longint frac;
        longint idx;
        longint l2;
        if (x == 0)
            return -589824;
        e = 15;
        while (((x >> e) & 1) == 0)
            e--;
        frac = x - (longint'(1) << e);
        if (e >= TABLE_ADDR_BITS_DEF)
            idx = frac >> (e - TABLE_ADDR_BITS_DEF);
        else
            idx = frac << (TABLE_ADDR_BITS_DEF - e);
        l2 = longint'(e - 16) * 65536 + log2_frac_tbl[idx];
        return round_shift(l2 * LOG10_2_Q16, 16);
    endfunction

    function automatic longint pow10_linear(input longint v);
        longint u;
        longint n;
        longint frac;
        longint sh;
        longint unsigned ent;
        longint unsigned val;
        u = round_shift(v * LOG2_10_Q16, 16);
        n = u >>> 16;
        frac = u - n * 65536;
        ent = exp2_tbl[frac >> (16 - TABLE_ADDR_BITS_DEF)];
        sh = n + 16 - 30;
        if (sh > 32)
            return LIN_LIMIT;
        if (sh >= 0)
        begin
            val = ent << sh;
            return (val > LIN_LIMIT) ? LIN_LIMIT : longint'(val);
        end
        if (sh <= -32)
            return 0;
        return longint'(ent >> (-sh));
    endfunction

    function automatic pixel_result_t transfer_pixel(input logic [15:0] b,
                                                     input logic [15:0] g,
                                                     input logic [15:0] r);
        longint rgb[3];
        longint lg[3];
        longint lab[3];
        longint lin[3];
        longint acc;
        longint v;
        logic [15:0] chan[3];
        pixel_result_t res;
        rgb[0] = r;
        rgb[1] = g;
        rgb[2] = b;
        res.clip = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += longint'(RGB_TO_LMS[i][j]) * rgb[j];
            lg[i] = log10_q16(round_shift(acc, 16));
        end
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += longint'(LMS_TO_LAB[i][j]) * lg[j];
            lab[i] = round_shift(round_shift(acc, 16) * longint'(gain_reg[i]), 12)
                     + longint'(offset_reg[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += longint'(LAB_TO_LMS[i][j]) * lab[j];
            lin[i] = pow10_linear(round_shift(acc, 16));
        end
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += longint'(LMS_TO_RGB[i][j]) * lin[j];
            v = round_shift(acc, 16);
            if (v < 0)
            begin
                v = 0;
                res.clip = 1'b1;
            end
            else if (v > 65535)
            begin
                v = 65535;
                res.clip = 1'b1;
            end
            chan[i] = v[15:0];
        end
        res.red = chan[0];
        res.green = chan[1];
        res.blue = chan[2];
        return res;
    endfunction

    // Both tables are built by their defining recurrences in Q.30.
    initial
    begin
        longint unsigned y;
        longint unsigned root;
        longint unsigned prod;
        longint frac;
        for (int i = 0; i < TBL_SIZE; i++)
        begin
            y = (longint'(1) << 30) + (longint'(i) << (30 - TABLE_ADDR_BITS_DEF));
            frac = 0;
            for (int k = 0; k < 16; k++)
            begin
                y = (y * y) >> 30;
                frac = frac << 1;
                if (y >= (longint'(1) << 31))
                begin
                    frac = frac | 1;
                    y = y >> 1;
                end
            end
            log2_frac_tbl[i] = frac;
            prod = longint'(1) << 30;
            root = longint'(1) << 31;
            for (int k = 1; k <= TABLE_ADDR_BITS_DEF; k++)
            begin
                root = int_sqrt(root << 30);
                if (((i >> (TABLE_ADDR_BITS_DEF - k)) & 1) != 0)
                    prod = (prod * root) >> 30;
            end
            exp2_tbl[i] = longint'(prod);
        end
    end

    initial
    begin
        failures = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                gain_reg[i] = GAIN_RESET;
                offset_reg[i] = '0;
            end
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_GAIN_L:       gain_reg[0] = cfg_wr_data[GAIN_BITS-1:0];
                    REG_GAIN_ALPHA:   gain_reg[1] = cfg_wr_data[GAIN_BITS-1:0];
                    REG_GAIN_BETA:    gain_reg[2] = cfg_wr_data[GAIN_BITS-1:0];
                    REG_OFFSET_L:     offset_reg[0] = cfg_wr_data;
                    REG_OFFSET_ALPHA: offset_reg[1] = cfg_wr_data;
                    REG_OFFSET_BETA:  offset_reg[2] = cfg_wr_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_pixels.push_back(transfer_pixel(blue_in, green_in, red_in));
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected transaction b=%h g=%h r=%h clip=%b",
                             $time, blue_out, green_out, red_out, clipped);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (blue_out !== want.blue)
                    begin
                        failures++;
                        $display("%0t: blue_out expected %h actual %h",
                                 $time, want.blue, blue_out);
                    end
                    if (green_out !== want.green)
                    begin
                        failures++;
                        $display("%0t: green_out expected %h actual %h",
                                 $time, want.green, green_out);
                    end
                    if (red_out !== want.red)
                    begin
                        failures++;
                        $display("%0t: red_out expected %h actual %h",
                                 $time, want.red, red_out);
                    end
                    if (clipped !== want.clip)
                    begin
                        failures++;
                        $display("%0t: clipped expected %b actual %b",
                                 $time, want.clip, clipped);
                    end
                end
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// ===== tb/tb_lab_color_transfer_pixel_core.sv =====
module tb_lab_color_transfer_pixel_core;
    import lcp_pkg::*;

    localparam logic [CFG_ADDR_BITS-1:0] UNUSED_REG_IDX = 3'd6;
    localparam logic [CFG_ADDR_BITS-1:0] LAST_REG_IDX   = 3'd7;
    localparam int PHASES = 9;
    localparam int ITEMS_PER_PHASE = 214;
    localparam int SETTLE_CYCLES = 24;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [15:0]              blue_in;
    logic [15:0]              green_in;
    logic [15:0]              red_in;
    logic                     out_valid;
    logic                     out_ready;
    logic [15:0]              blue_out;
    logic [15:0]              green_out;
    logic [15:0]              red_out;
    logic                     clipped;
    int                       failures;
    int                       pending;
    int                       burst_left;

    lab_color_transfer_pixel_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .blue_in(blue_in), .green_in(green_in), .red_in(red_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .blue_out(blue_out), .green_out(green_out), .red_out(red_out),
        .clipped(clipped)
    );

    lab_transfer_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .blue_in(blue_in), .green_in(green_in), .red_in(red_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .blue_out(blue_out), .green_out(green_out), .red_out(red_out),
        .clipped(clipped),
        .failures(failures), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

    // The receiver mixes several stall patterns and twice holds off for a
    // long stretch so that the pipeline fills and in_ready drops.
    initial
    begin
        int cyc;
        int mode;
        cyc = 0;
        mode = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 200 == 0)
                mode = $urandom_range(0, 3);
            if ((cyc >= 1500 && cyc < 1590) || (cyc >= 5000 && cyc < 5120))
                out_ready <= 1'b0;
            else
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 1);
                    2: out_ready <= ($urandom_range(0, 9) != 0);
                    default: out_ready <= (cyc % 5 != 0);
                endcase
        end
    end

    task automatic send_pixel(input logic [15:0] b, input logic [15:0] g,
                              input logic [15:0] r);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        in_valid <= 1'b1;
        blue_in <= b;
        green_in <= g;
        red_in <= r;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        burst_left--;
    endtask

    task automatic send_random_pixel();
        logic [15:0] v[3];
        int w;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                for (int i = 0; i < 3; i++)
                    v[i] = 16'($urandom);
            end
            2:
            begin
                v[0] = 16'($urandom);
                v[1] = v[0];
                v[2] = v[0];
            end
            3:
            begin
                // Narrow values exercise the small-exponent log lookup.
                for (int i = 0; i < 3; i++)
                begin
                    w = $urandom_range(0, 16);
                    v[i] = 16'($urandom & ((32'd1 << w) - 1));
                end
            end
            4:
            begin
                for (int i = 0; i < 3; i++)
                    v[i] = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            end
            default:
            begin
                for (int i = 0; i < 3; i++)
                    v[i] = 16'(16'h8000 + $urandom_range(0, 16'h3FFF));
            end
        endcase
        send_pixel(v[0], v[1], v[2]);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes an index beyond the map first and last with hostile values; they
    // must leave every register untouched.
    task automatic load_settings(input logic [15:0] g[3], input logic [23:0] o[3]);
        logic [CFG_ADDR_BITS-1:0] idx[8];
        logic [CFG_DATA_BITS-1:0] val[8];
        idx = '{UNUSED_REG_IDX, REG_GAIN_L, REG_GAIN_ALPHA, REG_GAIN_BETA,
                REG_OFFSET_L, REG_OFFSET_ALPHA, REG_OFFSET_BETA, LAST_REG_IDX};
        val[0] = 24'hFFFFFF;
        for (int i = 0; i < 3; i++)
        begin
            val[1 + i] = {8'($urandom), g[i]};
            val[4 + i] = o[i];
        end
        val[7] = 24'h800000;
        for (int i = 0; i < 8; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_addr <= idx[i];
            cfg_wr_data <= val[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] gains[3];
        logic [23:0] offs[3];
        logic [15:0] directed[20][3];
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        blue_in = '0;
        green_in = '0;
        red_in = '0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Black, full scale, single channels, one LSB, near-black, mid-scale and mixed values.
        directed = '{
            '{16'h0000, 16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF, 16'hFFFF},
            '{16'hFFFF, 16'h0000, 16'h0000}, '{16'h0000, 16'hFFFF, 16'h0000},
            '{16'h0000, 16'h0000, 16'hFFFF}, '{16'h0001, 16'h0001, 16'h0001},
            '{16'h0001, 16'h0000, 16'h0000}, '{16'h0000, 16'h0000, 16'h0001},
            '{16'h03FF, 16'h0400, 16'h0401}, '{16'h8000, 16'h8000, 16'h8000},
            '{16'h7FFF, 16'h7FFF, 16'h7FFF}, '{16'hAAAA, 16'h5555, 16'hAAAA},
            '{16'h5555, 16'hAAAA, 16'h5555}, '{16'h0002, 16'h0003, 16'h0004},
            '{16'hFFFE, 16'h0001, 16'h8001}, '{16'h1234, 16'h5678, 16'h9ABC},
            '{16'h00FF, 16'hFF00, 16'h0F0F}, '{16'hFFFF, 16'hFFFF, 16'h0000},
            '{16'h0000, 16'hFFFF, 16'hFFFF}, '{16'h4000, 16'h2000, 16'h1000}};
        for (int i = 0; i < 20; i++)
            send_pixel(directed[i][0], directed[i][1], directed[i][2]);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            for (int i = 0; i < 3; i++)
            begin
                case (p)
                    0:
                    begin
                        gains[i] = GAIN_RESET;
                        offs[i] = 24'd0;
                    end
                    1:
                    begin
                        // Largest gain and offset drive the exponent into overflow.
                        gains[i] = 16'hFFFF;
                        offs[i] = 24'h7FFFFF;
                    end
                    2:
                    begin
                        // Most negative offset drives L and M to zero and S into overflow.
                        gains[i] = 16'h0000;
                        offs[i] = 24'h800000;
                    end
                    3:
                    begin
                        gains[i] = 16'hFFFF;
                        offs[i] = 24'h800000;
                    end
                    4:
                    begin
                        gains[i] = 16'h0000;
                        offs[i] = 24'($signed($urandom_range(0, 262144)) - 131072);
                    end
                    default:
                    begin
                        gains[i] = 16'($urandom_range(2048, 6144));
                        offs[i] = 24'($signed($urandom_range(0, 262144)) - 131072);
                    end
                endcase
            end
            load_settings(gains, offs);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_pixel();
        end

        wait_idle();
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lcp_pkg.sv
hw/rtl/lcp_log2_rom.sv
hw/rtl/lcp_exp2_rom.sv
hw/rtl/lcp_log10.sv
hw/rtl/lcp_pow10.sv
hw/rtl/lab_color_transfer_pixel_core.sv
tb/lab_transfer_checker.sv
tb/tb_lab_color_transfer_pixel_core.sv
